>>> rtl/cdr_pkg.sv
package cdr_pkg;

	localparam logic [1:0] OP_LOAD_R = 2'd0;
	localparam logic [1:0] OP_LOAD_X = 2'd1;
	localparam logic [1:0] OP_RUN    = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NORM     = 2'd1;
	localparam logic [1:0] ST_ZERO_DIV = 2'd2;

	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic signed [31:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic        start;
		logic [63:0] rad;
	} sqrt_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] root;
	} sqrt_rsp_t;

	// magnitude and sign to a saturated 32-bit value
	function automatic logic signed [31:0] sat_mag(input logic [63:0] mag, input logic neg);
		logic [63:0] m;
		m = (mag > 64'h0000_0000_8000_0000) ? 64'h0000_0000_8000_0000 : mag;
		if (neg) begin
			sat_mag = ~m[31:0] + 32'd1;
		end else if (m[31]) begin
			sat_mag = 32'sh7FFF_FFFF;
		end else begin
			sat_mag = m[31:0];
		end
	endfunction

endpackage

>>> rtl/cdr_div.sv
module cdr_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cdr_pkg::div_req_t req,
	output cdr_pkg::div_rsp_t rsp
);

	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [31:0]   rem_q;
	logic [31:0]   den_q;
	logic          neg_q;
	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;

	logic [31:0]   mag_a;
	logic [31:0]   mag_b;
	logic [NW-1:0] numer;
	logic [32:0]   trial;
	logic [32:0]   diff;
	logic          ge;

	assign mag_a = req.num[31] ? (~req.num + 32'd1) : req.num;
	assign mag_b = req.den[31] ? (~req.den + 32'd1) : req.den;
	// rounding half of the divisor folded into the dividend
	assign numer = {mag_a, {FRAC_BITS{1'b0}}} + NW'(mag_b >> 1);

	assign trial = {rem_q, num_q[NW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(1));
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= numer;
			rem_q <= '0;
			den_q <= mag_b;
			neg_q <= req.num[31] ^ req.den[31];
		end else if (busy_q) begin
			rem_q <= ge ? diff[31:0] : trial[31:0];
			num_q <= {num_q[NW-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = cdr_pkg::sat_mag(64'(num_q), neg_q);

endmodule

>>> rtl/cdr_sqrt.sv
module cdr_sqrt (
	input  logic               clk,
	input  logic               arst_n,
	input  cdr_pkg::sqrt_req_t req,
	output cdr_pkg::sqrt_rsp_t rsp
);

	logic [63:0] rad_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	logic [34:0] remsh;
	logic [34:0] trial;
	logic        ge;

	// two radicand bits per step
	assign remsh = {rem_q[32:0], rad_q[63:62]};
	assign trial = {1'b0, root_q, 2'b01};
	assign ge    = remsh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == 6'd1);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rad_q  <= req.rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? 34'(remsh - trial) : remsh[33:0];
			root_q <= {root_q[30:0], ge};
			rad_q  <= {rad_q[61:0], 2'b00};
		end
	end

	assign rsp.done = done_q;
	assign rsp.root = root_q[31] ? 32'h7FFF_FFFF : root_q;

endmodule

>>> rtl/cholesky_rank_one_downdate_top.sv
// Rank-one Cholesky downdate, signed Q(FRAC_BITS) fixed point. Load requests (factor entries
// of the upper triangle, vector entries) are taken one per cycle. A run request stalls the
// input until the solve, the norm check, the Givens sweep and the emission of all
// DIM*(DIM+1)/2 entries are through. Its length is set by the shared bit-serial divider (DIM
// quotients in the solve, four per rotation) and the shared square-root unit (one, plus one per
// rotation), plus the solve terms, the norm terms, each rotation applied to an entry and each
// emitted entry; all factor accesses go through the factor memory with its registered read
// port. A norm above one or a zero divisor leaves the factor as it was and flags status.
module cholesky_rank_one_downdate_top #(
	parameter int DIM       = 4,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [1:0]         row_index,
	input  logic [1:0]         col_index,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         out_row,
	output logic [1:0]         out_col,
	output logic signed [31:0] out_value,
	output logic [1:0]         status,
	output logic               last_entry
);

	localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int AW = (DIM * DIM > 1) ? $clog2(DIM * DIM) : 1;
	localparam logic [63:0] ONE  = 64'd1 << (2 * FRAC_BITS);
	localparam logic [63:0] HALF = 64'd1 << (FRAC_BITS - 1);
	localparam logic [IW-1:0] LAST_IDX = IW'(DIM - 1);

	localparam logic [5:0] S_IDLE      = 6'd0;
	localparam logic [5:0] S_SV_START  = 6'd1;
	localparam logic [5:0] S_SV_RD     = 6'd2;
	localparam logic [5:0] S_SV_MUL    = 6'd3;
	localparam logic [5:0] S_SV_ACC    = 6'd4;
	localparam logic [5:0] S_SV_DIAG   = 6'd5;
	localparam logic [5:0] S_SV_DIV    = 6'd6;
	localparam logic [5:0] S_SV_DW     = 6'd7;
	localparam logic [5:0] S_NM_MUL    = 6'd8;
	localparam logic [5:0] S_NM_ACC    = 6'd9;
	localparam logic [5:0] S_NM_CHK    = 6'd10;
	localparam logic [5:0] S_NM_SW     = 6'd11;
	localparam logic [5:0] S_RT_SCALE  = 6'd12;
	localparam logic [5:0] S_RT_DA_GO  = 6'd13;
	localparam logic [5:0] S_RT_DA_W   = 6'd14;
	localparam logic [5:0] S_RT_DB_GO  = 6'd15;
	localparam logic [5:0] S_RT_DB_W   = 6'd16;
	localparam logic [5:0] S_RT_SQA    = 6'd17;
	localparam logic [5:0] S_RT_SQB    = 6'd18;
	localparam logic [5:0] S_RT_SQS    = 6'd19;
	localparam logic [5:0] S_RT_NRM_GO = 6'd20;
	localparam logic [5:0] S_RT_NRM_W  = 6'd21;
	localparam logic [5:0] S_RT_C_GO   = 6'd22;
	localparam logic [5:0] S_RT_C_W    = 6'd23;
	localparam logic [5:0] S_RT_S_GO   = 6'd24;
	localparam logic [5:0] S_RT_S_W    = 6'd25;
	localparam logic [5:0] S_RT_AL     = 6'd26;
	localparam logic [5:0] S_RT_AL2    = 6'd27;
	localparam logic [5:0] S_AP_START  = 6'd28;
	localparam logic [5:0] S_AP_RD     = 6'd29;
	localparam logic [5:0] S_AP_M1     = 6'd30;
	localparam logic [5:0] S_AP_M2     = 6'd31;
	localparam logic [5:0] S_AP_M3     = 6'd32;
	localparam logic [5:0] S_AP_M4     = 6'd33;
	localparam logic [5:0] S_AP_M5     = 6'd34;
	localparam logic [5:0] S_EM_RD     = 6'd35;
	localparam logic [5:0] S_EM_LD     = 6'd36;

	function automatic logic [AW-1:0] addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		addr = AW'(int'(r) * DIM + int'(c));
	endfunction

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		if (v[32] != v[31]) begin
			sat33 = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat33 = v[31:0];
		end
	endfunction

	function automatic logic signed [31:0] sat40(input logic signed [39:0] v);
		if ((v[39:31] != 9'h000) && (v[39:31] != 9'h1FF)) begin
			sat40 = v[39] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			sat40 = v[31:0];
		end
	endfunction

	// factor memory, single read port registered
	logic signed [31:0] tri_mem [DIM*DIM];
	logic signed [31:0] rd_data_q;
	logic [AW-1:0]      rd_addr;
	logic               mem_we;
	logic [AW-1:0]      mem_wa;
	logic signed [31:0] mem_wd;

	logic signed [31:0] vec_q [DIM];
	logic signed [31:0] s_q   [DIM];
	logic signed [31:0] cos_q [DIM];
	logic signed [31:0] sin_q [DIM];

	logic [5:0]    state_q;
	logic [IW-1:0] i_q;
	logic [IW-1:0] j_q;
	logic [1:0]    status_q;
	logic          out_valid_q;

	logic signed [39:0] acc_q;
	logic [63:0]        sum_q;
	logic signed [31:0] alpha_q;
	logic signed [31:0] scale_q;
	logic signed [31:0] a_q;
	logic signed [31:0] b_q;
	logic signed [31:0] nrm_q;
	logic signed [31:0] cur_q;
	logic signed [31:0] p1_q;
	logic signed [31:0] t_q;
	logic signed [31:0] xx_q;
	logic signed [63:0] prod_q;

	logic [1:0]         out_row_q;
	logic [1:0]         out_col_q;
	logic signed [31:0] out_value_q;
	logic [1:0]         out_status_q;
	logic               out_last_q;

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic               p_neg;
	logic [63:0]        p_mag;
	logic [63:0]        p_rnd;
	logic signed [31:0] qr;
	logic [64:0]        sum_add;
	logic [63:0]        sum_next;
	logic signed [31:0] s_abs;
	logic               in_acc;
	logic               load_ok;
	logic               out_free;
	logic               em_last;

	cdr_pkg::div_req_t  div_req;
	cdr_pkg::div_rsp_t  div_rsp;
	cdr_pkg::sqrt_req_t sqrt_req;
	cdr_pkg::sqrt_rsp_t sqrt_rsp;

	cdr_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	cdr_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sqrt_req),
		.rsp    (sqrt_rsp)
	);

	assign in_stall = (state_q != S_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign load_ok  = (int'(row_index) < DIM) && (int'(col_index) < DIM)
		&& (col_index >= row_index);
	assign out_free = !out_valid_q || !out_stall;
	assign em_last  = (i_q == LAST_IDX) && (j_q == LAST_IDX);

	// rounded product, ties away from zero
	assign p_neg = prod_q[63];
	assign p_mag = p_neg ? (~prod_q + 64'd1) : prod_q;
	assign p_rnd = (p_mag + HALF) >> FRAC_BITS;
	assign qr    = cdr_pkg::sat_mag(p_rnd, p_neg);

	assign sum_add  = {1'b0, sum_q} + {1'b0, prod_q};
	assign sum_next = sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];

	assign s_abs = (s_q[j_q] == 32'sh8000_0000) ? 32'sh7FFF_FFFF
		: (s_q[j_q][31] ? -s_q[j_q] : s_q[j_q]);

	always_comb begin
		mul_a = cos_q[j_q];
		mul_b = xx_q;
		case (state_q)
			S_SV_MUL: begin
				mul_a = rd_data_q;
				mul_b = s_q[j_q];
			end
			S_NM_MUL: begin
				mul_a = s_q[j_q];
				mul_b = s_q[j_q];
			end
			S_RT_SQA: begin
				mul_a = a_q;
				mul_b = a_q;
			end
			S_RT_SQB: begin
				mul_a = b_q;
				mul_b = b_q;
			end
			S_RT_AL: begin
				mul_a = scale_q;
				mul_b = nrm_q;
			end
			S_AP_M2: begin
				mul_a = sin_q[j_q];
				mul_b = cur_q;
			end
			S_AP_M3: begin
				mul_a = cos_q[j_q];
				mul_b = cur_q;
			end
			S_AP_M4: begin
				mul_a = sin_q[j_q];
				mul_b = xx_q;
			end
			default: begin
				mul_a = cos_q[j_q];
				mul_b = xx_q;
			end
		endcase
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = alpha_q;
		div_req.den   = scale_q;
		case (state_q)
			S_SV_DIV: begin
				div_req.start = (rd_data_q != 32'sd0);
				div_req.num   = sat40(acc_q);
				div_req.den   = rd_data_q;
			end
			S_RT_DA_GO: begin
				div_req.start = (scale_q != 32'sd0);
			end
			S_RT_DB_GO: begin
				div_req.start = 1'b1;
				div_req.num   = s_q[j_q];
			end
			S_RT_C_GO: begin
				div_req.start = (nrm_q != 32'sd0);
				div_req.num   = a_q;
				div_req.den   = nrm_q;
			end
			S_RT_S_GO: begin
				div_req.start = 1'b1;
				div_req.num   = b_q;
				div_req.den   = nrm_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	assign sqrt_req.start = ((state_q == S_NM_CHK) && (sum_q <= ONE))
		|| (state_q == S_RT_NRM_GO);
	assign sqrt_req.rad   = (state_q == S_NM_CHK) ? (ONE - sum_q) : sum_q;

	always_comb begin
		if (state_q == S_SV_DIAG) begin
			rd_addr = addr(i_q, i_q);
		end else if (state_q == S_EM_RD) begin
			rd_addr = addr(i_q, j_q);
		end else begin
			rd_addr = addr(j_q, i_q);
		end
	end

	assign mem_we = (in_acc && (operation == cdr_pkg::OP_LOAD_R) && load_ok)
		|| (state_q == S_AP_M5);
	assign mem_wa = (state_q == S_AP_M5) ? addr(j_q, i_q)
		: addr(IW'(row_index), IW'(col_index));
	assign mem_wd = (state_q == S_AP_M5) ? sat33(33'(p1_q) - 33'(qr)) : value;

	always_ff @(posedge clk) begin
		rd_data_q <= tri_mem[rd_addr];
		if (mem_we) begin
			tri_mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_acc && (operation == cdr_pkg::OP_LOAD_X) && (int'(row_index) < DIM)) begin
			vec_q[IW'(row_index)] <= value;
		end
		case (state_q)
			S_SV_START: acc_q <= 40'(vec_q[i_q]);
			S_SV_ACC:   acc_q <= acc_q - 40'(qr);
			S_SV_DW:    if (div_rsp.done) s_q[i_q] <= div_rsp.quo;
			S_NM_ACC:   sum_q <= sum_next;
			S_NM_SW:    if (sqrt_rsp.done) alpha_q <= sqrt_rsp.root;
			S_RT_SCALE: scale_q <= sat33(33'(alpha_q) + 33'(s_abs));
			S_RT_DA_W:  if (div_rsp.done) a_q <= div_rsp.quo;
			S_RT_DB_W:  if (div_rsp.done) b_q <= div_rsp.quo;
			S_RT_SQB:   sum_q <= prod_q;
			S_RT_SQS:   sum_q <= sum_next;
			S_RT_NRM_W: if (sqrt_rsp.done) nrm_q <= sqrt_rsp.root;
			S_RT_C_W:   if (div_rsp.done) cos_q[j_q] <= div_rsp.quo;
			S_RT_S_W:   if (div_rsp.done) sin_q[j_q] <= div_rsp.quo;
			S_RT_AL2:   alpha_q <= qr;
			S_AP_START: xx_q <= 32'sd0;
			S_AP_M1:    cur_q <= rd_data_q;
			S_AP_M2:    p1_q <= qr;
			S_AP_M3:    t_q <= sat33(33'(p1_q) + 33'(qr));
			S_AP_M4:    p1_q <= qr;
			S_AP_M5:    xx_q <= t_q;
			S_EM_LD: begin
				out_row_q    <= 2'(i_q);
				out_col_q    <= 2'(j_q);
				out_value_q  <= rd_data_q;
				out_status_q <= status_q;
				out_last_q   <= em_last;
			end
			default: begin
				if (state_q == S_NM_CHK && sum_q > ONE) begin
					sum_q <= sum_q;
				end
			end
		endcase
		if (state_q == S_SV_DW && div_rsp.done && i_q == LAST_IDX) begin
			sum_q <= 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			status_q    <= cdr_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_EM_LD) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && operation == cdr_pkg::OP_RUN) begin
						status_q <= cdr_pkg::ST_OK;
						i_q      <= '0;
						state_q  <= S_SV_START;
					end
				end
				S_SV_START: begin
					j_q     <= '0;
					state_q <= (i_q == '0) ? S_SV_DIAG : S_SV_RD;
				end
				S_SV_RD:  state_q <= S_SV_MUL;
				S_SV_MUL: state_q <= S_SV_ACC;
				S_SV_ACC: begin
					if (j_q == i_q - IW'(1)) begin
						state_q <= S_SV_DIAG;
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= S_SV_RD;
					end
				end
				S_SV_DIAG: state_q <= S_SV_DIV;
				S_SV_DIV: begin
					if (rd_data_q == 32'sd0) begin
						status_q <= cdr_pkg::ST_ZERO_DIV;
						i_q      <= '0;
						j_q      <= '0;
						state_q  <= S_EM_RD;
					end else begin
						state_q <= S_SV_DW;
					end
				end
				S_SV_DW: begin
					if (div_rsp.done) begin
						if (i_q == LAST_IDX) begin
							j_q     <= '0;
							state_q <= S_NM_MUL;
						end else begin
							i_q     <= i_q + IW'(1);
							state_q <= S_SV_START;
						end
					end
				end
				S_NM_MUL: state_q <= S_NM_ACC;
				S_NM_ACC: begin
					if (j_q == LAST_IDX) begin
						state_q <= S_NM_CHK;
					end else begin
						j_q     <= j_q + IW'(1);
						state_q <= S_NM_MUL;
					end
				end
				S_NM_CHK: begin
					if (sum_q > ONE) begin
						status_q <= cdr_pkg::ST_NORM;
						i_q      <= '0;
						j_q      <= '0;
						state_q  <= S_EM_RD;
					end else begin
						state_q <= S_NM_SW;
					end
				end
				S_NM_SW: begin
					if (sqrt_rsp.done) begin
						j_q     <= LAST_IDX;
						state_q <= S_RT_SCALE;
					end
				end
				S_RT_SCALE: state_q <= S_RT_DA_GO;
				S_RT_DA_GO: begin
					if (scale_q == 32'sd0) begin
						status_q <= cdr_pkg::ST_ZERO_DIV;
						i_q      <= '0;
						j_q      <= '0;
						state_q  <= S_EM_RD;
					end else begin
						state_q <= S_RT_DA_W;
					end
				end
				S_RT_DA_W:   if (div_rsp.done) state_q <= S_RT_DB_GO;
				S_RT_DB_GO:  state_q <= S_RT_DB_W;
				S_RT_DB_W:   if (div_rsp.done) state_q <= S_RT_SQA;
				S_RT_SQA:    state_q <= S_RT_SQB;
				S_RT_SQB:    state_q <= S_RT_SQS;
				S_RT_SQS:    state_q <= S_RT_NRM_GO;
				S_RT_NRM_GO: state_q <= S_RT_NRM_W;
				S_RT_NRM_W:  if (sqrt_rsp.done) state_q <= S_RT_C_GO;
				S_RT_C_GO: begin
					if (nrm_q == 32'sd0) begin
						status_q <= cdr_pkg::ST_ZERO_DIV;
						i_q      <= '0;
						j_q      <= '0;
						state_q  <= S_EM_RD;
					end else begin
						state_q <= S_RT_C_W;
					end
				end
				S_RT_C_W:  if (div_rsp.done) state_q <= S_RT_S_GO;
				S_RT_S_GO: state_q <= S_RT_S_W;
				S_RT_S_W:  if (div_rsp.done) state_q <= S_RT_AL;
				S_RT_AL:   state_q <= S_RT_AL2;
				S_RT_AL2: begin
					if (j_q == '0) begin
						i_q     <= '0;
						state_q <= S_AP_START;
					end else begin
						j_q     <= j_q - IW'(1);
						state_q <= S_RT_SCALE;
					end
				end
				S_AP_START: begin
					j_q     <= i_q;
					state_q <= S_AP_RD;
				end
				S_AP_RD: state_q <= S_AP_M1;
				S_AP_M1: state_q <= S_AP_M2;
				S_AP_M2: state_q <= S_AP_M3;
				S_AP_M3: state_q <= S_AP_M4;
				S_AP_M4: state_q <= S_AP_M5;
				S_AP_M5: begin
					if (j_q != '0) begin
						j_q     <= j_q - IW'(1);
						state_q <= S_AP_RD;
					end else if (i_q == LAST_IDX) begin
						i_q     <= '0;
						j_q     <= '0;
						state_q <= S_EM_RD;
					end else begin
						i_q     <= i_q + IW'(1);
						state_q <= S_AP_START;
					end
				end
				S_EM_RD: if (out_free) state_q <= S_EM_LD;
				S_EM_LD: begin
					if (em_last) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_EM_RD;
						if (j_q == LAST_IDX) begin
							i_q <= i_q + IW'(1);
							j_q <= i_q + IW'(1);
						end else begin
							j_q <= j_q + IW'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign out_row    = out_row_q;
	assign out_col    = out_col_q;
	assign out_value  = out_value_q;
	assign status     = out_status_q;
	assign last_entry = out_last_q;

	// output register must have drained before a new entry is loaded
	a_em_ld_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EM_LD |-> !out_valid_q)
		else $error("emit load over a pending result");

	a_out_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EM_LD))
		else $error("result shown without emit load");

	// factor only rewritten on a clean run
	a_apply_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_AP_M5) |-> (status_q == cdr_pkg::ST_OK))
		else $error("factor rewritten on a failed run");

endmodule

>>> bench/tb_top.sv
module tb_top;

	localparam int N = 4;
	localparam int FB = 16;
	localparam int TRI_ENTRIES = N * (N + 1) / 2;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int ONE_Q = 32'h0001_0000;
	localparam int CYCLE_LIMIT = 4000000;
	localparam int RANDOM_ITEMS = 430;

	typedef struct {
		logic [1:0]         row;
		logic [1:0]         col;
		logic signed [31:0] val;
		logic [1:0]         st;
		logic               last;
	} entry_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         operation;
	logic [1:0]         row_index;
	logic [1:0]         col_index;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         out_row;
	logic [1:0]         out_col;
	logic signed [31:0] out_value;
	logic [1:0]         status;
	logic               last_entry;

	// predictor state
	int factor_r[N*N];
	int vec_x[N];
	int sin_t[N];
	int cos_t[N];

	entry_t expected_entries[$];
	int     fail_count;
	int     cycles;
	int     counted_items;
	bit     quiet;
	int     hold_request;
	int     stall_left;

	cholesky_rank_one_downdate_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .row_index(row_index), .col_index(col_index), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_row(out_row), .out_col(out_col), .out_value(out_value),
		.status(status), .last_entry(last_entry)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------- fixed-point arithmetic ----------------
	function automatic logic [63:0] mag_of(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic int sat_w(longint v);
		if (v > longint'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
		if (v < -longint'(64'h8000_0000)) return 32'sh8000_0000;
		return int'(v);
	endfunction

	function automatic int from_mag(logic [63:0] m, bit neg);
		logic [63:0] c;
		c = (m > 64'h8000_0000) ? 64'h8000_0000 : m;
		return sat_w(neg ? -longint'(c) : longint'(c));
	endfunction

	function automatic int fx_mul(int a, int b);
		longint p;
		logic [63:0] m;
		p = longint'(a) * longint'(b);
		m = (mag_of(p) + (64'd1 << (FB - 1))) >> FB;
		return from_mag(m, p < 0);
	endfunction

	function automatic int fx_div(int a, int b, inout bit bad);
		logic [63:0] ma, mb, q;
		if (b == 0) begin
			bad = 1'b1;
			return 0;
		end
		ma = mag_of(a) << FB;
		mb = mag_of(b);
		q = (ma + mb / 2) / mb;
		return from_mag(q, (a < 0) != (b < 0));
	endfunction

	function automatic int fx_abs(int v);
		return (v < 0) ? sat_w(-longint'(v)) : v;
	endfunction

	function automatic logic [63:0] sq_acc(logic [63:0] sum, int v);
		logic [63:0] m, sq;
		m = mag_of(v);
		sq = m * m;
		return (sum > ~64'd0 - sq) ? ~64'd0 : sum + sq;
	endfunction

	function automatic int fx_sqrt(logic [63:0] v);
		logic [63:0] res, bits;
		res = 0;
		bits = 64'd1 << 62;
		while (bits > v) bits = bits >> 2;
		while (bits != 0) begin
			if (v >= res + bits) begin
				v = v - (res + bits);
				res = (res >> 1) + bits;
			end else begin
				res = res >> 1;
			end
			bits = bits >> 2;
		end
		return (res > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : int'(res);
	endfunction

	// solve, norm check and Givens sweep; returns the status code
	function automatic logic [1:0] downdate_factor();
		int s[N];
		int r[N*N];
		int alpha, scale, a, b, nrm, xx, c, sn, cur, t;
		longint acc;
		logic [63:0] sum, one;
		bit bad;
		sum = 0;
		one = 64'd1 << (2 * FB);
		bad = 1'b0;
		for (int i = 0; i < N; i++) begin
			acc = vec_x[i];
			for (int j = 0; j < i; j++) acc -= fx_mul(factor_r[j*N+i], s[j]);
			s[i] = fx_div(sat_w(acc), factor_r[i*N+i], bad);
			if (bad) return cdr_pkg::ST_ZERO_DIV;
		end
		for (int i = 0; i < N; i++) sum = sq_acc(sum, s[i]);
		if (sum > one) return cdr_pkg::ST_NORM;
		alpha = fx_sqrt(one - sum);
		for (int j = N - 1; j >= 0; j--) begin
			scale = sat_w(longint'(alpha) + fx_abs(s[j]));
			a = fx_div(alpha, scale, bad);
			b = fx_div(s[j], scale, bad);
			if (bad) return cdr_pkg::ST_ZERO_DIV;
			nrm = fx_sqrt(sq_acc(sq_acc(0, a), b));
			cos_t[j] = fx_div(a, nrm, bad);
			sin_t[j] = fx_div(b, nrm, bad);
			if (bad) return cdr_pkg::ST_ZERO_DIV;
			alpha = fx_mul(scale, nrm);
		end
		r = factor_r;
		for (int i = 0; i < N; i++) begin
			xx = 0;
			for (int k = i; k >= 0; k--) begin
				c = cos_t[k];
				sn = sin_t[k];
				cur = r[k*N+i];
				t = sat_w(longint'(fx_mul(c, xx)) + fx_mul(sn, cur));
				r[k*N+i] = sat_w(longint'(fx_mul(c, cur)) - fx_mul(sn, xx));
				xx = t;
			end
		end
		factor_r = r;
		return cdr_pkg::ST_OK;
	endfunction

	task automatic predict_request(logic [1:0] op, logic [1:0] row, logic [1:0] col, int v);
		logic [1:0] st;
		entry_t e;
		int n;
		case (op)
			cdr_pkg::OP_LOAD_R: begin
				if (col >= row) factor_r[row*N+col] = v;
			end
			cdr_pkg::OP_LOAD_X: begin
				vec_x[row] = v;
			end
			cdr_pkg::OP_RUN: begin
				st = downdate_factor();
				n = 0;
				for (int i = 0; i < N; i++) begin
					for (int j = i; j < N; j++) begin
						e.row = 2'(i);
						e.col = 2'(j);
						e.val = factor_r[i*N+j];
						e.st = st;
						e.last = (n == TRI_ENTRIES - 1);
						expected_entries.push_back(e);
						n++;
					end
				end
			end
			default: ;
		endcase
	endtask

	// ---------------- drivers ----------------
	function automatic int pick_gap();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_request(logic [1:0] op, logic [1:0] row, logic [1:0] col, int v);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		row_index <= row;
		col_index <= col;
		value     <= v;
		do @(posedge clk); while (in_stall);
		predict_request(op, row, col, v);
		counted_items++;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_entries.size() != 0) @(posedge clk);
	endtask

	function automatic int well_diag();
		return $urandom_range(ONE_Q, 4 * ONE_Q);
	endfunction

	function automatic int well_off();
		return $signed($urandom_range(0, ONE_Q)) - ONE_Q / 2;
	endfunction

	function automatic int well_vec();
		return $signed($urandom_range(0, ONE_Q / 2)) - ONE_Q / 4;
	endfunction

	task automatic load_well_formed();
		for (int i = 0; i < N; i++)
			for (int j = i; j < N; j++)
				send_request(cdr_pkg::OP_LOAD_R, 2'(i), 2'(j),
					(i == j) ? well_diag() : well_off());
		for (int i = 0; i < N; i++)
			send_request(cdr_pkg::OP_LOAD_X, 2'(i), 2'd0, well_vec());
	endtask

	// ---------------- tests ----------------
	task automatic test_directed();
		// identity factor, x = e0: norm exactly one
		for (int i = 0; i < N; i++)
			for (int j = i; j < N; j++)
				send_request(cdr_pkg::OP_LOAD_R, 2'(i), 2'(j), (i == j) ? ONE_Q : 0);
		send_request(cdr_pkg::OP_LOAD_X, 2'd0, 2'd0, ONE_Q);
		send_request(cdr_pkg::OP_LOAD_X, 2'd1, 2'd0, 0);
		send_request(cdr_pkg::OP_LOAD_X, 2'd2, 2'd0, 0);
		send_request(cdr_pkg::OP_LOAD_X, 2'd3, 2'd3, 0);
		send_request(cdr_pkg::OP_RUN, 2'd0, 2'd0, 0);
		// ignored items: lower triangle and the spare opcode
		send_request(cdr_pkg::OP_LOAD_R, 2'd3, 2'd0, 32'sh7FFF_FFFF);
		send_request(OP_UNUSED, 2'd2, 2'd1, 32'sh8000_0000);
		// norm above one
		send_request(cdr_pkg::OP_LOAD_X, 2'd1, 2'd2, 32'sh7FFF_FFFF);
		send_request(cdr_pkg::OP_RUN, 2'd3, 2'd3, -1);
		// zero diagonal
		send_request(cdr_pkg::OP_LOAD_X, 2'd1, 2'd0, 0);
		send_request(cdr_pkg::OP_LOAD_R, 2'd2, 2'd2, 0);
		send_request(cdr_pkg::OP_RUN, 2'd1, 2'd2, 0);
		// value extremes in the factor
		send_request(cdr_pkg::OP_LOAD_R, 2'd2, 2'd2, 32'sh8000_0000);
		send_request(cdr_pkg::OP_LOAD_R, 2'd0, 2'd3, 32'sh7FFF_FFFF);
		send_request(cdr_pkg::OP_RUN, 2'd0, 2'd0, 0);
		wait_drained();
	endtask

	task automatic test_random();
		int r;
		while (counted_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 9);
			quiet = ($urandom_range(0, 7) == 0);
			if (r < 3) begin
				load_well_formed();
				send_request(cdr_pkg::OP_RUN, 2'($urandom), 2'($urandom), $urandom);
			end else if (r < 7) begin
				// partial reload with sane values, then a repeated downdate
				repeat ($urandom_range(0, 3)) begin
					logic [1:0] a, b;
					a = 2'($urandom);
					b = 2'($urandom);
					if (b < a) b = a;
					send_request(cdr_pkg::OP_LOAD_R, a, b,
						(a == b) ? well_diag() : well_off());
				end
				repeat ($urandom_range(0, 2))
					send_request(cdr_pkg::OP_LOAD_X, 2'($urandom), 2'($urandom),
						well_vec());
				send_request(cdr_pkg::OP_RUN, 2'($urandom), 2'($urandom), $urandom);
			end else begin
				repeat ($urandom_range(1, 4))
					send_request(2'($urandom_range(0, 3)), 2'($urandom), 2'($urandom),
						$urandom);
			end
		end
		quiet = 1'b0;
		wait_drained();
	endtask

	task automatic test_backpressure();
		load_well_formed();
		hold_request = 4000;
		send_request(cdr_pkg::OP_RUN, 2'd0, 2'd0, 0);
		send_request(cdr_pkg::OP_LOAD_X, 2'd2, 2'd0, well_vec());
		send_request(cdr_pkg::OP_RUN, 2'd0, 2'd0, 0);
		send_request(cdr_pkg::OP_LOAD_X, 2'd0, 2'd0, well_vec());
		wait_drained();
		send_request(cdr_pkg::OP_RUN, 2'd0, 2'd0, 0);
		wait_drained();
	endtask

	// ---------------- receiver and checker ----------------
	always @(posedge clk) begin
		if (hold_request > 0) begin
			stall_left = hold_request;
			hold_request = 0;
		end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) >= 60) begin
			stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
			                                          : $urandom_range(1, 3);
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		entry_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_entries.size() == 0) begin
				$error("unexpected entry row %0d col %0d value %0h", out_row, out_col, out_value);
				fail_count++;
			end else begin
				e = expected_entries.pop_front();
				if (out_row !== e.row) begin
					$error("out_row: expected %0d, got %0d", e.row, out_row);
					fail_count++;
				end
				if (out_col !== e.col) begin
					$error("out_col: expected %0d, got %0d", e.col, out_col);
					fail_count++;
				end
				if (out_value !== e.val) begin
					$error("out_value: expected %0h, got %0h", e.val, out_value);
					fail_count++;
				end
				if (status !== e.st) begin
					$error("status: expected %0d, got %0d", e.st, status);
					fail_count++;
				end
				if (last_entry !== e.last) begin
					$error("last_entry: expected %0b, got %0b", e.last, last_entry);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		fail_count = 0;
		cycles = 0;
		counted_items = 0;
		quiet = 1'b0;
		hold_request = 0;
		stall_left = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = cdr_pkg::OP_LOAD_R;
		row_index = 2'd0;
		col_index = 2'd0;
		value = 0;
		for (int i = 0; i < N * N; i++) factor_r[i] = 0;
		for (int i = 0; i < N; i++) begin
			vec_x[i] = 0;
			sin_t[i] = 0;
			cos_t[i] = 0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		repeat (100) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
